>>> rtl/lruk_pkg.sv
// Shared types, codes and defaults for the LRU-K page cache.
`timescale 1ns / 1ps

package lruk_pkg;

   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_ID_BITS     = 16;

   localparam int OPCODE_BITS = 2;
   localparam int POS_BITS    = 4;
   localparam int HITS_BITS   = 4;
   localparam int K_BITS      = 4;
   localparam int CAP_BITS    = 5;
   localparam int CSR_BITS    = 5;
   localparam int CSR_IDX_BITS = 2;
   localparam int RSP_ID_BITS = 16;
   localparam int COUNT_BITS  = 5;

   localparam logic [OPCODE_BITS-1:0] OP_ACCESS     = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_READ_HIST  = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_READ_CACHE = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_K_HITS   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAPACITY = 2'd1;

   localparam logic [K_BITS-1:0]   K_HITS_RESET   = 4'd2;
   localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 5'd16;

   // Shift command broadcast to every cell of one queue.
   typedef struct packed {
      logic remove;       // take one entry out of the queue
      logic remove_head;  // the entry taken out is the head, not the matched one
      logic append;       // write the key at the append position
   } queue_op_type;

endpackage

>>> rtl/lruk_cell.sv
// One queue position: a history slot with its hit count and a cache slot.
`timescale 1ns / 1ps

module lruk_cell #(
   parameter int QUEUE_DEPTH = lruk_pkg::DEF_QUEUE_DEPTH,
   parameter int ID_BITS     = lruk_pkg::DEF_ID_BITS,
   parameter int CELL_INDEX  = 0
) (
   input  logic                                clock,
   input  logic [ID_BITS-1:0]                  key,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]    hist_len,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]    cache_len,
   input  lruk_pkg::queue_op_type              hist_op,
   input  lruk_pkg::queue_op_type              cache_op,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]    hist_app_idx,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]    cache_app_idx,
   input  logic [lruk_pkg::HITS_BITS-1:0]      hist_new_hits,
   input  logic [ID_BITS-1:0]                  next_hist_id,
   input  logic [lruk_pkg::HITS_BITS-1:0]      next_hist_hits,
   input  logic [ID_BITS-1:0]                  next_cache_id,
   input  logic                                hist_seen_in,
   input  logic [lruk_pkg::HITS_BITS-1:0]      hist_hits_in,
   input  logic                                cache_seen_in,
   output logic                                hist_seen_out,
   output logic [lruk_pkg::HITS_BITS-1:0]      hist_hits_out,
   output logic                                cache_seen_out,
   output logic [ID_BITS-1:0]                  hist_id,
   output logic [lruk_pkg::HITS_BITS-1:0]      hist_hits,
   output logic [ID_BITS-1:0]                  cache_id
);
   import lruk_pkg::*;

   localparam int LEN_BITS = $clog2(QUEUE_DEPTH+1);
   localparam logic [LEN_BITS-1:0] MY_INDEX = LEN_BITS'(CELL_INDEX);

   logic [ID_BITS-1:0]   hist_id_ff, hist_id_in;
   logic [HITS_BITS-1:0] hist_hits_ff, hist_hits_in_val;
   logic [ID_BITS-1:0]   cache_id_ff, cache_id_in;
   logic                 hist_match, cache_match;
   logic                 hist_shift, cache_shift;

   assign hist_match  = (MY_INDEX < hist_len) && (hist_id_ff == key);
   assign cache_match = (MY_INDEX < cache_len) && (cache_id_ff == key);

   // The seen flag ripples toward the tail, so the first match wins and every
   // cell at or after it knows it lies behind the removed entry.
   assign hist_seen_out  = hist_seen_in | hist_match;
   assign cache_seen_out = cache_seen_in | cache_match;
   assign hist_hits_out  = hist_seen_in ? hist_hits_in :
                           (hist_match ? hist_hits_ff : '0);

   assign hist_shift  = hist_op.remove && (hist_op.remove_head || hist_seen_out);
   assign cache_shift = cache_op.remove && (cache_op.remove_head || cache_seen_out);

   always_comb begin
      hist_id_in       = hist_id_ff;
      hist_hits_in_val = hist_hits_ff;
      if (hist_op.append && (hist_app_idx == MY_INDEX)) begin
         hist_id_in       = key;
         hist_hits_in_val = hist_new_hits;
      end else if (hist_shift) begin
         hist_id_in       = next_hist_id;
         hist_hits_in_val = next_hist_hits;
      end
   end

   always_comb begin
      cache_id_in = cache_id_ff;
      if (cache_op.append && (cache_app_idx == MY_INDEX)) begin
         cache_id_in = key;
      end else if (cache_shift) begin
         cache_id_in = next_cache_id;
      end
   end

   always_ff @(posedge clock) begin
      hist_id_ff   <= hist_id_in;
      hist_hits_ff <= hist_hits_in_val;
      cache_id_ff  <= cache_id_in;
   end

   assign hist_id   = hist_id_ff;
   assign hist_hits = hist_hits_ff;
   assign cache_id  = cache_id_ff;

endmodule

>>> rtl/lru_k_page_cache.sv
// Top level of the LRU-K page cache: command decode, queue control and results.
`timescale 1ns / 1ps

// LRU-K page cache. Every command is accepted when start is high: busy stays low,
// so a command may be issued on every clock, and its result appears on the
// rsp_ ports, flagged by rsp_valid, for exactly one cycle on the clock after
// the transfer. The receiver cannot stall, so it must take each result in that
// cycle. The figure of one command per cycle is set by the row of
// QUEUE_DEPTH cells, which match the page against every slot and shift both
// queues in the same clock. The queues start empty after reset with no clearing
// pass; k_hits and capacity may only be written while no command is pending.
module lru_k_page_cache #(
   parameter int QUEUE_DEPTH = lruk_pkg::DEF_QUEUE_DEPTH,
   parameter int ID_BITS     = lruk_pkg::DEF_ID_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [lruk_pkg::OPCODE_BITS-1:0]    req_opcode,
   input  logic [ID_BITS-1:0]                  req_page_id,
   input  logic [lruk_pkg::POS_BITS-1:0]       req_position,
   output logic                                rsp_valid,
   output logic                                rsp_cache_hit,
   output logic                                rsp_history_hit,
   output logic                                rsp_promoted,
   output logic                                rsp_cache_evict_valid,
   output logic [lruk_pkg::RSP_ID_BITS-1:0]    rsp_cache_evict_id,
   output logic                                rsp_history_evict_valid,
   output logic [lruk_pkg::RSP_ID_BITS-1:0]    rsp_history_evict_id,
   output logic                                rsp_entry_valid,
   output logic [lruk_pkg::RSP_ID_BITS-1:0]    rsp_entry_id,
   output logic [lruk_pkg::COUNT_BITS-1:0]     rsp_history_count,
   output logic [lruk_pkg::COUNT_BITS-1:0]     rsp_cache_count,
   input  logic                                csr_write_enable,
   input  logic [lruk_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [lruk_pkg::CSR_BITS-1:0]       csr_wdata
);
   import lruk_pkg::*;

   localparam int LEN_BITS = $clog2(QUEUE_DEPTH+1);
   localparam int CMP_BITS = (LEN_BITS > CAP_BITS) ? LEN_BITS : CAP_BITS;

   // Configuration.
   logic [K_BITS-1:0]   k_hits_ff;
   logic [CAP_BITS-1:0] capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_hits_ff   <= K_HITS_RESET;
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_K_HITS:   k_hits_ff   <= csr_wdata[K_BITS-1:0];
            CSR_CAPACITY: capacity_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Queue lengths.
   logic [LEN_BITS-1:0] hist_len_ff, hist_len_in;
   logic [LEN_BITS-1:0] cache_len_ff, cache_len_in;

   // Cell row; the entry past the last cell is the zero neighbor of the tail.
   logic [ID_BITS-1:0]   hist_id   [QUEUE_DEPTH+1];
   logic [HITS_BITS-1:0] hist_hits [QUEUE_DEPTH+1];
   logic [ID_BITS-1:0]   cache_id  [QUEUE_DEPTH+1];
   logic                 hist_seen  [QUEUE_DEPTH+1];
   logic [HITS_BITS-1:0] hist_chain [QUEUE_DEPTH+1];
   logic                 cache_seen [QUEUE_DEPTH+1];

   queue_op_type        hist_op, cache_op;
   logic [LEN_BITS-1:0] hist_app_idx, cache_app_idx;
   logic [HITS_BITS-1:0] hist_new_hits;

   assign hist_id[QUEUE_DEPTH]   = '0;
   assign hist_hits[QUEUE_DEPTH] = '0;
   assign cache_id[QUEUE_DEPTH]  = '0;
   assign hist_seen[0]  = 1'b0;
   assign hist_chain[0] = '0;
   assign cache_seen[0] = 1'b0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      lruk_cell #(
         .QUEUE_DEPTH (QUEUE_DEPTH),
         .ID_BITS     (ID_BITS),
         .CELL_INDEX  (i)
      ) u_cell (
         .clock          (clock),
         .key            (req_page_id),
         .hist_len       (hist_len_ff),
         .cache_len      (cache_len_ff),
         .hist_op        (hist_op),
         .cache_op       (cache_op),
         .hist_app_idx   (hist_app_idx),
         .cache_app_idx  (cache_app_idx),
         .hist_new_hits  (hist_new_hits),
         .next_hist_id   (hist_id[i+1]),
         .next_hist_hits (hist_hits[i+1]),
         .next_cache_id  (cache_id[i+1]),
         .hist_seen_in   (hist_seen[i]),
         .hist_hits_in   (hist_chain[i]),
         .cache_seen_in  (cache_seen[i]),
         .hist_seen_out  (hist_seen[i+1]),
         .hist_hits_out  (hist_chain[i+1]),
         .cache_seen_out (cache_seen[i+1]),
         .hist_id        (hist_id[i]),
         .hist_hits      (hist_hits[i]),
         .cache_id       (cache_id[i])
      );
   end

   logic                 accept;
   logic [K_BITS-1:0]    k_eff;
   logic [CMP_BITS-1:0]  cap_eff;
   logic                 hist_full, cache_full;
   logic                 found_cache, found_hist;
   logic [HITS_BITS-1:0] found_hits;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign k_eff   = (k_hits_ff == '0) ? K_BITS'(1) : k_hits_ff;
   assign cap_eff = (capacity_ff == '0) ? CMP_BITS'(1) :
                    (CMP_BITS'(capacity_ff) > CMP_BITS'(QUEUE_DEPTH)) ?
                    CMP_BITS'(QUEUE_DEPTH) : CMP_BITS'(capacity_ff);
   assign hist_full  = CMP_BITS'(hist_len_ff) >= cap_eff;
   assign cache_full = CMP_BITS'(cache_len_ff) >= cap_eff;

   assign found_cache = cache_seen[QUEUE_DEPTH];
   assign found_hist  = hist_seen[QUEUE_DEPTH];
   assign found_hits  = hist_chain[QUEUE_DEPTH];

   // Result fields of the current command.
   logic                 cache_hit, history_hit, promoted;
   logic                 cache_evict, history_evict;
   logic                 entry_valid;
   logic [ID_BITS-1:0]   entry_id;
   logic                 admit;

   always_comb begin
      hist_op       = '0;
      cache_op      = '0;
      hist_new_hits = HITS_BITS'(1);
      cache_hit     = 1'b0;
      history_hit   = 1'b0;
      promoted      = 1'b0;
      cache_evict   = 1'b0;
      history_evict = 1'b0;
      admit         = 1'b0;

      if (accept && (req_opcode == OP_ACCESS)) begin
         if (found_cache) begin
            cache_hit       = 1'b1;
            cache_op.remove = 1'b1;
            cache_op.append = 1'b1;
         end else if (k_eff == K_BITS'(1)) begin
            promoted = 1'b1;
            admit    = 1'b1;
         end else if (!found_hist) begin
            hist_op.append = 1'b1;
            if (hist_full) begin
               history_evict       = 1'b1;
               hist_op.remove      = 1'b1;
               hist_op.remove_head = 1'b1;
            end
         end else begin
            history_hit    = 1'b1;
            hist_op.remove = 1'b1;
            if (({1'b0, found_hits} + 5'd1) < {1'b0, k_eff}) begin
               hist_op.append = 1'b1;
               hist_new_hits  = found_hits + HITS_BITS'(1);
            end else begin
               promoted = 1'b1;
               admit    = 1'b1;
            end
         end

         // Admission into the cache evicts its head when it is full.
         if (admit) begin
            cache_op.append = 1'b1;
            if (cache_full) begin
               cache_evict          = 1'b1;
               cache_op.remove      = 1'b1;
               cache_op.remove_head = 1'b1;
            end
         end
      end

      hist_app_idx  = hist_len_ff - LEN_BITS'(hist_op.remove);
      cache_app_idx = cache_len_ff - LEN_BITS'(cache_op.remove);
      hist_len_in   = hist_app_idx + LEN_BITS'(hist_op.append);
      cache_len_in  = cache_app_idx + LEN_BITS'(cache_op.append);
   end

   // Position reads pick one cell of the row.
   always_comb begin
      entry_valid = 1'b0;
      entry_id    = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (CMP_BITS'(req_position) == CMP_BITS'(i)) begin
            if ((req_opcode == OP_READ_HIST) &&
                (CMP_BITS'(req_position) < CMP_BITS'(hist_len_ff))) begin
               entry_valid = 1'b1;
               entry_id    = hist_id[i];
            end else if ((req_opcode == OP_READ_CACHE) &&
                         (CMP_BITS'(req_position) < CMP_BITS'(cache_len_ff))) begin
               entry_valid = 1'b1;
               entry_id    = cache_id[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_len_ff  <= '0;
         cache_len_ff <= '0;
      end else begin
         hist_len_ff  <= hist_len_in;
         cache_len_ff <= cache_len_in;
      end
   end

   // Result register.
   logic                   rsp_valid_ff;
   logic                   rsp_cache_hit_ff, rsp_history_hit_ff, rsp_promoted_ff;
   logic                   rsp_cache_evict_valid_ff, rsp_history_evict_valid_ff;
   logic [RSP_ID_BITS-1:0] rsp_cache_evict_id_ff, rsp_history_evict_id_ff;
   logic                   rsp_entry_valid_ff;
   logic [RSP_ID_BITS-1:0] rsp_entry_id_ff;
   logic [COUNT_BITS-1:0]  rsp_history_count_ff, rsp_cache_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_cache_hit_ff           <= cache_hit;
         rsp_history_hit_ff         <= history_hit;
         rsp_promoted_ff            <= promoted;
         rsp_cache_evict_valid_ff   <= cache_evict;
         rsp_cache_evict_id_ff      <= cache_evict ? RSP_ID_BITS'(cache_id[0]) : '0;
         rsp_history_evict_valid_ff <= history_evict;
         rsp_history_evict_id_ff    <= history_evict ? RSP_ID_BITS'(hist_id[0]) : '0;
         rsp_entry_valid_ff         <= entry_valid;
         rsp_entry_id_ff            <= RSP_ID_BITS'(entry_id);
         rsp_history_count_ff       <= COUNT_BITS'(CMP_BITS'(hist_len_in));
         rsp_cache_count_ff         <= COUNT_BITS'(CMP_BITS'(cache_len_in));
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_cache_hit           = rsp_cache_hit_ff;
   assign rsp_history_hit         = rsp_history_hit_ff;
   assign rsp_promoted            = rsp_promoted_ff;
   assign rsp_cache_evict_valid   = rsp_cache_evict_valid_ff;
   assign rsp_cache_evict_id      = rsp_cache_evict_id_ff;
   assign rsp_history_evict_valid = rsp_history_evict_valid_ff;
   assign rsp_history_evict_id    = rsp_history_evict_id_ff;
   assign rsp_entry_valid         = rsp_entry_valid_ff;
   assign rsp_entry_id            = rsp_entry_id_ff;
   assign rsp_history_count       = rsp_history_count_ff;
   assign rsp_cache_count         = rsp_cache_count_ff;

   // Every transfer gives exactly one result on the next clock.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(accept))
      else $error("result strobe does not follow the command transfer");

   // Queue lengths never grow past the row of cells.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (CMP_BITS'(hist_len_ff) <= CMP_BITS'(QUEUE_DEPTH)) &&
      (CMP_BITS'(cache_len_ff) <= CMP_BITS'(QUEUE_DEPTH)))
      else $error("queue length beyond depth");

   // The cache only evicts when a page is admitted.
   a_evict_admit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cache_evict_valid |-> rsp_promoted && !rsp_cache_hit)
      else $error("cache eviction without admission");

   // History evicts only for a page new to both queues.
   a_hist_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_history_evict_valid |->
         !rsp_history_hit && !rsp_cache_hit && !rsp_promoted)
      else $error("history eviction on a hit");

endmodule
